// ----- hdl/cfc_pkg.sv -----
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame checker.
// Used by every module of the crc16_frame_checker block; depends on nothing.
`default_nettype none

package cfc_pkg;

	localparam int COUNT_W = 9;

	localparam logic [COUNT_W-1:0] HDR_LEN   = 9'd8;
	localparam logic [COUNT_W-1:0] CRC_LEN   = 9'd2;
	localparam logic [COUNT_W-1:0] MIN_FRAME = 9'd10;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [1:0] VERDICT_OK        = 2'd0;
	localparam logic [1:0] VERDICT_SHORT     = 2'd1;
	localparam logic [1:0] VERDICT_LENGTH    = 2'd2;
	localparam logic [1:0] VERDICT_CRC       = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_frame;
	} cfc_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_done;
		logic [1:0] verdict;
		logic [7:0] version;
		logic [7:0] network_id;
		logic [7:0] message_type;
		logic [7:0] source_address;
		logic [7:0] dest_address;
		logic [7:0] sequence_number;
		logic [7:0] flag_bits;
		logic [7:0] payload_length;
	} cfc_out_t;

	// MSB-first CRC update over one byte: eight shift steps on a 16-bit value.
	function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/cfc_frame_core.sv -----
// Frame state and per-byte decode: byte counter, running CRC, header capture and verdict.
// Depends on cfc_pkg for the item types, constants and the CRC byte update.
`default_nettype none

module cfc_frame_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire cfc_pkg::cfc_in_t item,
	output cfc_pkg::cfc_out_t     result
);
	import cfc_pkg::*;

	logic [COUNT_W-1:0] byte_count_q;
	logic [15:0]        crc_q;
	logic [7:0]         header_q [8];
	logic [15:0]        rx_crc_q;

	logic [COUNT_W-1:0] pos;
	logic [COUNT_W-1:0] pay_end;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] expect_len;
	logic               in_header;
	logic               in_payload;
	logic               crc_lo;
	logic               crc_hi;
	logic [15:0]        crc_next;
	logic [15:0]        rx_crc_next;
	logic [7:0]         header_next [8];
	logic [1:0]         verdict;

	assign pos        = byte_count_q;
	assign in_header  = pos < HDR_LEN;
	assign pay_end    = HDR_LEN + {1'b0, header_q[7]};
	assign in_payload = !in_header && (pos < pay_end);
	assign crc_lo     = !in_header && (pos == pay_end);
	assign crc_hi     = !in_header && (pos == pay_end + 9'd1);
	assign count_next = (pos < COUNT_MAX) ? pos + 9'd1 : COUNT_MAX;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			header_next[i] = (in_header && pos[2:0] == 3'(i)) ? item.rx_byte : header_q[i];
		end
	end

	assign crc_next = (in_header || in_payload) ? crc16_byte(crc_q, item.rx_byte) : crc_q;

	always_comb begin
		rx_crc_next = rx_crc_q;
		if (crc_lo) begin
			rx_crc_next[7:0] = item.rx_byte;
		end
		if (crc_hi) begin
			rx_crc_next[15:8] = item.rx_byte;
		end
	end

	// The length check uses the header as it stands after this byte.
	assign expect_len = HDR_LEN + CRC_LEN + {1'b0, header_next[7]};

	always_comb begin
		if (count_next < MIN_FRAME) begin
			verdict = VERDICT_SHORT;
		end else if (count_next != expect_len) begin
			verdict = VERDICT_LENGTH;
		end else if (rx_crc_next != crc_next) begin
			verdict = VERDICT_CRC;
		end else begin
			verdict = VERDICT_OK;
		end
	end

	always_comb begin
		result                 = '0;
		result.payload_byte    = item.rx_byte;
		result.payload_valid   = in_payload;
		result.frame_done      = item.end_of_frame;
		if (item.end_of_frame) begin
			result.verdict         = verdict;
			result.version         = header_next[0];
			result.network_id      = header_next[1];
			result.message_type    = header_next[2];
			result.source_address  = header_next[3];
			result.dest_address    = header_next[4];
			result.sequence_number = header_next[5];
			result.flag_bits       = header_next[6];
			result.payload_length  = header_next[7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= CRC_INIT;
			rx_crc_q     <= '0;
			for (int i = 0; i < 8; i++) begin
				header_q[i] <= '0;
			end
		end else if (fire) begin
			if (item.end_of_frame) begin
				byte_count_q <= '0;
				crc_q        <= CRC_INIT;
				rx_crc_q     <= '0;
				for (int i = 0; i < 8; i++) begin
					header_q[i] <= '0;
				end
			end else begin
				byte_count_q <= count_next;
				crc_q        <= crc_next;
				rx_crc_q     <= rx_crc_next;
				for (int i = 0; i < 8; i++) begin
					header_q[i] <= header_next[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cfc_out_buffer.sv -----
// Result register with a skid entry, so the core can finish a request while the receiver stalls.
// Depends on cfc_pkg for the result type.
`default_nettype none

module cfc_out_buffer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cfc_pkg::cfc_out_t push_data,
	output logic                   ready,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output cfc_pkg::cfc_out_t      result_item
);
	import cfc_pkg::*;

	logic     out_valid_q;
	logic     skid_valid_q;
	cfc_out_t out_q;
	cfc_out_t skid_q;
	logic     pop;

	assign ready        = !skid_valid_q;
	assign pop          = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/crc16_frame_checker.sv -----
// Top level of the length-prefixed frame checker: input register, frame core, result buffer.
// Depends on cfc_pkg, cfc_frame_core and cfc_out_buffer.
//
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_item) carries one frame byte per request,
//   with end_of_frame set on the last byte. The result channel (result_valid, result_stall,
//   result_item) returns exactly one result per byte, in order: the byte echoed, a payload
//   flag, and on the last byte the verdict and the eight header fields.
//   A byte accepted into the input register is decoded against the frame state and shows on
//   result_item once the result register takes it. While byte_stall is low, throughput is
//   one byte per cycle, set by the combinational CRC update and counter step.
//   When the receiver stalls, the result register holds its request and one more result
//   goes to a skid entry; once that entry is full, byte_stall rises while a byte waits in the
//   input register, and drops again as soon as the receiver takes a result.
//   Reset clears the frame state (count zero, CRC 0xFFFF, header zero) and empties both
//   registers. The frame state also returns to that point after every last byte.
`default_nettype none

module crc16_frame_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire cfc_pkg::cfc_in_t  byte_item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output cfc_pkg::cfc_out_t      result_item
);
	import cfc_pkg::*;

	logic     item_valid_s1;
	cfc_in_t  item_s1;
	logic     buf_ready;
	logic     advance;
	cfc_out_t core_result;

	assign advance    = item_valid_s1 && buf_ready;
	assign byte_stall = item_valid_s1 && !buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			item_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	cfc_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (core_result)
	);

	cfc_out_buffer u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (advance),
		.push_data    (core_result),
		.ready        (buf_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

`default_nettype wire

// ----- hdl/cfc_checker.sv -----
// Port-level checks for crc16_frame_checker, bound to the top level.
// Depends on cfc_pkg for the channel types and verdict codes.
`default_nettype none

module cfc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              byte_valid,
	input wire logic              byte_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire cfc_pkg::cfc_out_t result_item
);
	import cfc_pkg::*;

	// A held result stays offered until taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	// The input side only backs up when a result is waiting.
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid)
		else $error("byte channel stalled with no pending result");

	// Mid-frame results carry no verdict and no header.
	a_midframe_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.frame_done |->
			result_item.verdict == VERDICT_OK && result_item.version == 8'd0 &&
			result_item.payload_length == 8'd0 && result_item.flag_bits == 8'd0)
		else $error("header fields set on a byte that is not the last");

	// A good frame ends on its CRC byte, never inside the payload.
	a_ok_ends_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.frame_done && result_item.verdict == VERDICT_OK |->
			!result_item.payload_valid)
		else $error("frame reported good while ending inside the payload");

	// With both result entries empty, a new result is offered once its byte has passed the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && !byte_stall, 2))
		else $error("result appeared without a matching byte request");

endmodule

bind crc16_frame_checker cfc_checker u_cfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);

`default_nettype wire

// ----- verif/frame_verdict_monitor.sv -----
// Watches both channels of crc16_frame_checker, predicts every result and compares it.
// Depends on cfc_pkg for the request and result types and for the frame constants.
`timescale 1ns / 100ps

package frame_tb_pkg;

	// Bit-serial CRC-16/CCITT-FALSE step, most significant data bit first.
	function automatic logic [15:0] crc_ccitt_step(logic [15:0] acc, logic [7:0] data);
		logic [15:0] r;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			if (r[15] ^ data[k])
				r = {r[14:0], 1'b0} ^ cfc_pkg::CRC_POLY;
			else
				r = {r[14:0], 1'b0};
		end
		return r;
	endfunction

endpackage

module frame_verdict_monitor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              byte_stall,
	input  cfc_pkg::cfc_in_t  byte_item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  cfc_pkg::cfc_out_t result_item,
	output int                fail_count,
	output int                pending
);
	import cfc_pkg::*;
	import frame_tb_pkg::*;

	logic [8:0]  frame_pos;
	logic [15:0] crc_acc;
	logic [15:0] rx_crc;
	logic [7:0]  hdr_bytes [8];
	cfc_out_t    awaited_results [$];
	cfc_out_t    want;

	function automatic void clear_frame();
		frame_pos = '0;
		crc_acc = CRC_INIT;
		rx_crc = '0;
		foreach (hdr_bytes[i])
			hdr_bytes[i] = '0;
	endfunction

	function automatic cfc_out_t decode_byte(cfc_in_t req);
		cfc_out_t res;
		int pos;
		int plen;
		res = '0;
		pos = frame_pos;
		plen = hdr_bytes[7];
		res.payload_byte = req.rx_byte;
		res.frame_done = req.end_of_frame;
		if (pos < HDR_LEN) begin
			hdr_bytes[pos] = req.rx_byte;
			crc_acc = crc_ccitt_step(crc_acc, req.rx_byte);
		end else if (pos < HDR_LEN + plen) begin
			res.payload_valid = 1'b1;
			crc_acc = crc_ccitt_step(crc_acc, req.rx_byte);
		end else if (pos == HDR_LEN + plen) begin
			rx_crc[7:0] = req.rx_byte;
		end else if (pos == HDR_LEN + plen + 1) begin
			rx_crc[15:8] = req.rx_byte;
		end
		frame_pos = (pos < COUNT_MAX) ? 9'(pos + 1) : COUNT_MAX;
		if (req.end_of_frame) begin
			// The length byte may have arrived with this very request.
			plen = hdr_bytes[7];
			if (frame_pos < MIN_FRAME)
				res.verdict = VERDICT_SHORT;
			else if (int'(frame_pos) != HDR_LEN + CRC_LEN + plen)
				res.verdict = VERDICT_LENGTH;
			else if (rx_crc != crc_acc)
				res.verdict = VERDICT_CRC;
			else
				res.verdict = VERDICT_OK;
			res.version = hdr_bytes[0];
			res.network_id = hdr_bytes[1];
			res.message_type = hdr_bytes[2];
			res.source_address = hdr_bytes[3];
			res.dest_address = hdr_bytes[4];
			res.sequence_number = hdr_bytes[5];
			res.flag_bits = hdr_bytes[6];
			res.payload_length = hdr_bytes[7];
			clear_frame();
		end
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("payload_byte", want.payload_byte, result_item.payload_byte);
					check_field("payload_valid", want.payload_valid, result_item.payload_valid);
					check_field("frame_done", want.frame_done, result_item.frame_done);
					check_field("verdict", want.verdict, result_item.verdict);
					check_field("version", want.version, result_item.version);
					check_field("network_id", want.network_id, result_item.network_id);
					check_field("message_type", want.message_type, result_item.message_type);
					check_field("source_address", want.source_address,
						result_item.source_address);
					check_field("dest_address", want.dest_address, result_item.dest_address);
					check_field("sequence_number", want.sequence_number,
						result_item.sequence_number);
					check_field("flag_bits", want.flag_bits, result_item.flag_bits);
					check_field("payload_length", want.payload_length,
						result_item.payload_length);
				end
			end
			if (byte_valid && !byte_stall)
				awaited_results.push_back(decode_byte(byte_item));
			pending = awaited_results.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for crc16_frame_checker: clock, reset, frame stimulus and the final verdict.
// Depends on cfc_pkg, the block itself and frame_verdict_monitor (with frame_tb_pkg).
`timescale 1ns / 100ps

module tb_top;
	import cfc_pkg::*;
	import frame_tb_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     byte_valid;
	logic     byte_stall;
	cfc_in_t  byte_item;
	logic     result_valid;
	logic     result_stall;
	cfc_out_t result_item;
	logic     idle_on;
	int       fail_count;
	int       pending;
	int       bytes_sent;
	logic [7:0] frame_bytes [$];

	crc16_frame_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	frame_verdict_monitor mon (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #1 clk = ~clk;

	// Entered and left at a falling edge; the request is held until it is taken.
	task automatic push_byte(input logic [7:0] data, input logic eof);
		int gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= '{rx_byte: data, end_of_frame: eof};
		do
			@(posedge clk);
		while (byte_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Appends the CRC of everything queued so far, low byte first.
	function automatic void append_crc();
		logic [15:0] acc;
		acc = CRC_INIT;
		foreach (frame_bytes[i])
			acc = crc_ccitt_step(acc, frame_bytes[i]);
		frame_bytes.push_back(acc[7:0]);
		frame_bytes.push_back(acc[15:8]);
	endfunction

	function automatic void build_frame(int plen);
		frame_bytes.delete();
		repeat (7)
			frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'(plen));
		repeat (plen)
			frame_bytes.push_back(8'($urandom));
		append_crc();
	endfunction

	// Receiver: holds off a random number of cycles, then takes one result.
	initial begin
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = idle_on ? $urandom_range(0, 19) : 0;
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int f;
		int kind;
		int cut;
		int plen;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		idle_on = 1'b1;
		bytes_sent = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// A lone byte is a frame far too short.
		frame_bytes = '{8'h00};
		send_frame();
		// Smallest good frame, all header bytes at their maximum except the length.
		frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		append_crc();
		send_frame();
		// One payload byte, header zero apart from its length, damaged CRC high byte.
		frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
		append_crc();
		frame_bytes[frame_bytes.size() - 1] ^= 8'h80;
		send_frame();

		f = 0;
		while (bytes_sent < 1420) begin
			idle_on = ($urandom_range(0, 3) != 0);
			plen = ($urandom_range(0, 24) == 0) ? $urandom_range(25, 255)
				: $urandom_range(0, 24);
			if (f == 4)
				plen = 255;
			build_frame(plen);
			kind = $urandom_range(0, 9);
			if (f == 2) begin
				// Runs the byte counter into saturation.
				repeat ($urandom_range(515, 530) - frame_bytes.size())
					frame_bytes.push_back(8'($urandom));
			end else begin
				case (kind)
					0: frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)] ^=
						8'(1 << $urandom_range(0, 7));
					1: begin
						cut = $urandom_range(1, frame_bytes.size() - 1);
						while (frame_bytes.size() > cut)
							void'(frame_bytes.pop_back());
					end
					2: repeat ($urandom_range(1, 6))
						frame_bytes.push_back(8'($urandom));
					3: begin
						frame_bytes.delete();
						repeat ($urandom_range(1, 30))
							frame_bytes.push_back(8'($urandom));
					end
					4: frame_bytes[$urandom_range(0, frame_bytes.size() - 3)] ^=
						8'(1 << $urandom_range(0, 7));
					default: ;
				endcase
			end
			send_frame();
			f++;
		end
		byte_valid <= 1'b0;

		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/cfc_pkg.sv
hdl/cfc_frame_core.sv
hdl/cfc_out_buffer.sv
hdl/crc16_frame_checker.sv
hdl/cfc_checker.sv
verif/frame_verdict_monitor.sv
verif/tb_top.sv
